/* hdl/hbc_pkg.sv */
// Shared types, constants and codes for the hue blob centroid block.
package hbc_pkg;

   localparam int FRAME_ROWS = 120;
   localparam int FRAME_COLS = 160;
   localparam int FRAME_SIZE = FRAME_ROWS * FRAME_COLS;

   localparam int ROW_W = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
   localparam int COL_W = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
   localparam int SUM_W = 22;
   localparam int CNT_W = 15;
   localparam int DIV_W = 15;   // divisor width of the shared divider
   localparam int REM_W = DIV_W + 1;
   localparam int QUO_W = 32;
   localparam int DIG_W = 4;    // digit counter width (up to eight 4-bit digits)

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(32767);
   localparam logic [13:0]      HUE_SCALE = 14'd10723;
   localparam logic [7:0]       THRESHOLD_RESET = 8'd166;
   localparam logic [7:0]       OFFSET_RESET = 8'd158;

   // Register indexes on the configuration port
   localparam logic REG_HUE_THRESHOLD = 1'b0;
   localparam logic REG_COLUMN_OFFSET = 1'b1;

   // Sextant base codes: 0, 2 and 4 sextants
   localparam logic [1:0] BASE_RED   = 2'd0;
   localparam logic [1:0] BASE_GREEN = 2'd1;
   localparam logic [1:0] BASE_BLUE  = 2'd2;

   typedef struct packed {
      logic       valid;    // no two channels tie
      logic       last;
      logic       neg;      // sign of the hue numerator
      logic [7:0] num_mag;  // |numerator|
      logic [7:0] den;      // max - min
      logic [1:0] base;
   } pix_type;

   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] rem_init;
      logic [QUO_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
      logic [DIG_W-1:0] digits;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDIV,
      ST_MUL,
      ST_ACC,
      ST_FIN,
      ST_RDIV,
      ST_CDIV,
      ST_FDIV,
      ST_EMIT
   } back_state_type;

endpackage

/* hdl/hbc_front.sv */
// Front end: unpacks a BGR565 beat (red in bits 4:0) and classifies its hue sextant.
module hbc_front import hbc_pkg::*; (
   input  logic [15:0] pixel,
   input  logic        frame_last,
   output pix_type     pix
);

   logic [7:0] r, g, b;

   always_comb begin
      r = {pixel[4:0], 3'b000};
      g = {pixel[10:5], 2'b00};
      b = {pixel[15:11], 3'b000};
      pix = '0;
      pix.last = frame_last;
      pix.valid = 1'b1;
      // pick numerator, span and base from the channel order
      if (r > b && b > g) begin
         pix.neg = 1'b1; pix.num_mag = b - g; pix.den = r - g; pix.base = BASE_RED;
      end else if (r > g && g > b) begin
         pix.neg = 1'b0; pix.num_mag = g - b; pix.den = r - b; pix.base = BASE_RED;
      end else if (g > r && r > b) begin
         pix.neg = 1'b1; pix.num_mag = r - b; pix.den = g - b; pix.base = BASE_GREEN;
      end else if (g > b && b > r) begin
         pix.neg = 1'b0; pix.num_mag = b - r; pix.den = g - r; pix.base = BASE_GREEN;
      end else if (b > r && r > g) begin
         pix.neg = 1'b0; pix.num_mag = r - g; pix.den = b - g; pix.base = BASE_BLUE;
      end else if (b > g && g > r) begin
         pix.neg = 1'b1; pix.num_mag = g - r; pix.den = b - r; pix.base = BASE_BLUE;
      end else begin
         pix.valid = 1'b0;
      end
   end

endmodule

/* hdl/hbc_queue.sv */
// Two-entry queue between the classifying front end and the back end.
module hbc_queue import hbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  pix_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output pix_type rd_data,
   output logic    empty
);

   pix_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/hbc_divider.sv */
// Shared restoring divider, four quotient bits per cycle.
module hbc_divider import hbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] sh_ff, sh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff;
   logic [DIG_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // four shift-and-subtract steps per digit
   always_comb begin
      logic [REM_W-1:0] r;
      logic [QUO_W-1:0] s;
      logic [QUO_W-1:0] q;
      r = rem_ff;
      s = sh_ff;
      q = quo_ff;
      for (int i = 0; i < 4; i++) begin
         r = {r[REM_W-2:0], s[QUO_W-1]};
         s = {s[QUO_W-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r = r - {1'b0, dvs_ff};
            q = {q[QUO_W-2:0], 1'b1};
         end else begin
            q = {q[QUO_W-2:0], 1'b0};
         end
      end
      rem_in  = r;
      sh_in   = s;
      quo_in  = q;
      cnt_in  = cnt_ff - DIG_W'(1);
      done_in = (cnt_ff == DIG_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         cnt_ff  <= req.digits;
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         sh_ff  <= req.dividend;
         quo_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
         quo_ff <= quo_in;
      end
   end

endmodule

/* hdl/hbc_back.sv */
// Back end: hue scaling, threshold, accumulation and end-of-frame results.
module hbc_back import hbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  pix_type     q_data,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic [7:0]  hue_threshold,
   input  logic [7:0]  column_offset,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_centroid_row,
   output logic [7:0]  rsp_centroid_col,
   output logic [14:0] rsp_hit_total,
   output logic [15:0] rsp_fill_ratio,
   output logic        rsp_empty_frame
);

   back_state_type   state_ff, state_in;
   pix_type          pix_ff;
   logic [15:0]      mag_ff;
   logic [32:0]      prod_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [SUM_W-1:0] col_sum_ff, col_sum_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic [6:0]       res_row_ff;
   logic [7:0]       res_col_ff;
   logic [15:0]      res_ratio_ff;
   logic             out_full_ff, out_full_in;
   div_req_type      dreq;
   logic             div_done;
   logic [QUO_W-1:0] div_quo;
   logic signed [20:0] s_val;
   logic [18:0]      s_pos;
   logic [9:0]       rot_sum;
   logic [COL_W-1:0] rot_col;
   logic             hit;
   logic             clear_frame;

   hbc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (dreq),
      .done     (div_done),
      .quotient (div_quo)
   );

   // signed sextant position in Q.16, folded into the positive range
   always_comb begin
      logic signed [20:0] base_v;
      case (pix_ff.base)
         BASE_RED:   base_v = 21'sd0;
         BASE_GREEN: base_v = 21'sd131072;
         BASE_BLUE:  base_v = 21'sd262144;
         default:    base_v = 21'sd0;
      endcase
      s_val = pix_ff.neg ? base_v - $signed({5'b0, mag_ff}) : base_v + $signed({5'b0, mag_ff});
      if (s_val < 0) begin
         s_val = s_val + 21'sd393216;
      end
      s_pos = s_val[18:0];
   end

   // rotate the column modulo the frame width
   always_comb begin
      rot_sum = 10'(col_ff) + 10'(column_offset);
      if (rot_sum >= 10'(2 * FRAME_COLS)) begin
         rot_sum = rot_sum - 10'(2 * FRAME_COLS);
      end else if (rot_sum >= 10'(FRAME_COLS)) begin
         rot_sum = rot_sum - 10'(FRAME_COLS);
      end
      rot_col = rot_sum[COL_W-1:0];
   end

   assign hit = pix_ff.valid && (prod_ff[32:24] > {1'b0, hue_threshold}) && (hit_ff < COUNT_MAX);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      dreq        = '0;
      out_full_in = out_full_ff && !pop;
      clear_frame = 1'b0;
      row_sum_in  = row_sum_ff;
      col_sum_in  = col_sum_ff;
      hit_in      = hit_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.valid) begin
                  dreq.start    = 1'b1;
                  dreq.rem_init = REM_W'(q_data.num_mag);
                  dreq.dividend = '0;
                  dreq.divisor  = DIV_W'(q_data.den);
                  dreq.digits   = DIG_W'(4);
                  state_in      = ST_HDIV;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_HDIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (hit) begin
               row_sum_in = row_sum_ff + SUM_W'(row_ff);
               col_sum_in = col_sum_ff + SUM_W'(rot_col);
               hit_in     = hit_ff + CNT_W'(1);
            end
            if (col_ff == COL_W'(FRAME_COLS - 1)) begin
               col_in = '0;
               row_in = (row_ff == ROW_W'(FRAME_ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            state_in = pix_ff.last ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (hit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               dreq.start    = 1'b1;
               dreq.rem_init = '0;
               dreq.dividend = {2'b00, row_sum_ff, 8'h00};
               dreq.divisor  = DIV_W'(hit_ff);
               dreq.digits   = DIG_W'(6);
               state_in      = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               dreq.start    = 1'b1;
               dreq.rem_init = '0;
               dreq.dividend = {2'b00, col_sum_ff, 8'h00};
               dreq.divisor  = DIV_W'(hit_ff);
               dreq.digits   = DIG_W'(6);
               state_in      = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (div_done) begin
               dreq.start    = 1'b1;
               dreq.rem_init = '0;
               dreq.dividend = {1'b0, hit_ff, 16'h0000};
               dreq.divisor  = DIV_W'(FRAME_SIZE);
               dreq.digits   = DIG_W'(8);
               state_in      = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full_ff) begin
               out_full_in = 1'b1;
               clear_frame = 1'b1;
               row_sum_in  = '0;
               col_sum_in  = '0;
               hit_in      = '0;
               row_in      = '0;
               col_in      = '0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
         row_sum_ff  <= '0;
         col_sum_ff  <= '0;
         hit_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
         row_sum_ff  <= row_sum_in;
         col_sum_ff  <= col_sum_in;
         hit_ff      <= hit_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   // hold the working beat, quotients and product
   always_ff @(posedge clock) begin
      if (q_pop) begin
         pix_ff <= q_data;
      end
      if (state_ff == ST_HDIV && div_done) begin
         mag_ff <= div_quo[15:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= 33'(s_pos) * 33'(HUE_SCALE);
      end
      if (state_ff == ST_RDIV && div_done) begin
         res_row_ff <= div_quo[6:0];
      end
      if (state_ff == ST_CDIV && div_done) begin
         res_col_ff <= div_quo[7:0];
      end
      if (state_ff == ST_FDIV && div_done) begin
         res_ratio_ff <= (div_quo > QUO_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
      end
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (clear_frame) begin
         if (hit_ff == '0) begin
            rsp_centroid_row <= '0;
            rsp_centroid_col <= '0;
            rsp_hit_total    <= '0;
            rsp_fill_ratio   <= '0;
            rsp_empty_frame  <= 1'b1;
         end else begin
            rsp_centroid_row <= res_row_ff;
            rsp_centroid_col <= res_col_ff;
            rsp_hit_total    <= hit_ff;
            rsp_fill_ratio   <= res_ratio_ff;
            rsp_empty_frame  <= 1'b0;
         end
      end
   end

   assign empty = !out_full_ff;

`ifndef SYNTHESIS
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < ROW_W'(FRAME_ROWS)) else $error("row position out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < COL_W'(FRAME_COLS)) else $error("column position out of range");
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !out_full_ff |=> out_full_ff && hit_ff == '0)
      else $error("result not loaded or frame not cleared");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("queue popped while busy");
`endif

endmodule

/* hdl/hue_blob_centroid.sv */
// Top level of the hue blob centroid: configuration registers and wiring.
//
// Input channel: one BGR565 pixel per beat in raster order, req_frame_last set
// on the last pixel of a frame; a beat is taken when push is high and full low.
// Result channel: one beat per frame (centroid row and column, hit total, fill
// ratio in Q0.16, empty-frame flag), shown while empty is low and taken by pop.
// Configuration: hue_threshold at byte address 0, column_offset at 4; write
// only while the block is idle.
// Back end: a pixel with a valid hue is fetched, divided on the 4-bit-per-cycle
// hue divider, multiplied and accumulated; a pixel with tied channels is fetched
// and accumulated. The next pixel is fetched only after the accumulate step. A
// two-entry queue after the classifier absorbs input bursts.
// Frame end: after the accumulate step of the last pixel, the row, column and
// fill-ratio divisions run in turn on the shared divider before the result is
// posted; an empty frame skips the divisions.
// If the receiver stalls, the result waits in its output register; the back end
// keeps taking pixels until the next frame end has to be posted, then the queue fills.
// Reset: sums, count and position clear, registers return to 166 and 158.
module hue_blob_centroid import hbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_pixel,
   input  logic        req_frame_last,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_centroid_row,
   output logic [7:0]  rsp_centroid_col,
   output logic [14:0] rsp_hit_total,
   output logic [15:0] rsp_fill_ratio,
   output logic        rsp_empty_frame,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0] thr_ff, off_ff;
   pix_type    front_pix;
   pix_type    q_data;
   logic       q_empty, q_pop;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         off_ff <= OFFSET_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_HUE_THRESHOLD: thr_ff <= pwdata[7:0];
            REG_COLUMN_OFFSET: off_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_HUE_THRESHOLD: prdata = {24'h0, thr_ff};
         REG_COLUMN_OFFSET: prdata = {24'h0, off_ff};
         default:           prdata = '0;
      endcase
   end

   hbc_front u_front (
      .pixel      (req_pixel),
      .frame_last (req_frame_last),
      .pix        (front_pix)
   );

   hbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_pix),
      .full    (full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   hbc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_data           (q_data),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .hue_threshold    (thr_ff),
      .column_offset    (off_ff),
      .empty            (empty),
      .pop              (pop),
      .rsp_centroid_row (rsp_centroid_row),
      .rsp_centroid_col (rsp_centroid_col),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_fill_ratio   (rsp_fill_ratio),
      .rsp_empty_frame  (rsp_empty_frame)
   );

endmodule
